>>> rtl/core/u_tube_cell_classifier_macros.svh
// Assertion helpers for the classifier modules.
// Each expects signals named clock and reset in the enclosing module.
`ifndef U_TUBE_CELL_CLASSIFIER_MACROS_SVH
`define U_TUBE_CELL_CLASSIFIER_MACROS_SVH

// Check that the consequent follows whenever the antecedent holds.
`define UTCC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error(msg);

// Check that a condition never holds.
`define UTCC_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

>>> rtl/core/utcc_pkg.sv
package utcc_pkg;

   // Grid extent; cells at or beyond it classify as nothing.
   localparam int GRID_W = 1024;
   localparam int GRID_H = 1024;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEFT_LEG_X,
      CSR_RIGHT_LEG_X,
      CSR_BOTTOM_ROW,
      CSR_TOP_ROW,
      CSR_TUBE_WIDTH,
      CSR_WALL_THICKNESS,
      CSR_LEFT_FILL_LEVEL,
      CSR_RIGHT_FILL_LEVEL
   } csr_index_type;

   // Normalized tube geometry, all lengths in quarter cells.
   typedef struct packed {
      logic [12:0] cx;
      logic [12:0] cy;
      logic [12:0] lc;
      logic [12:0] rc;
      logic [10:0] hw;
      logic [11:0] envh;
      logic [12:0] top_y;
      logic [12:0] ll_y;
      logic [12:0] rl_y;
      logic [23:0] och_sq;
      logic [21:0] ich_sq;
      logic        ich_pos;
      logic [25:0] oenv_sq;
      logic [21:0] ienv_sq;
      logic        ienv_pos;
   } geom_type;

endpackage

>>> rtl/core/utcc_geom.sv
module utcc_geom (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [utcc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [utcc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output utcc_pkg::geom_type               geom
);

   typedef struct packed {
      logic [9:0]         left_x;
      logic [9:0]         right_x;
      logic [9:0]         bottom;
      logic [9:0]         top;
      logic [9:0]         width;
      logic [7:0]         wall;
      logic signed [10:0] left_fill;
      logic signed [10:0] right_fill;
   } cfg_type;

   // Ordered corners, swapped legs.
   typedef struct packed {
      logic [9:0]         lx;
      logic [9:0]         rx;
      logic [9:0]         bot;
      logic [9:0]         top;
      logic [9:0]         w;
      logic [7:0]         wall;
      logic signed [10:0] ll;
      logic signed [10:0] rl;
   } g1_type;

   typedef struct packed {
      logic [10:0]        hw;
      logic [11:0]        envh;
      logic [12:0]        lc;
      logic [12:0]        rc;
      logic [12:0]        cx;
      logic [10:0]        rb;
      logic [12:0]        cy;
      logic [9:0]         bot;
      logic [9:0]         top;
      logic signed [10:0] ll;
      logic signed [10:0] rl;
   } g2_type;

   typedef struct packed {
      logic [10:0]        top;
      logic [11:0]        och;
      logic [10:0]        ich;
      logic               ich_pos;
      logic [12:0]        oenv;
      logic [10:0]        ienv;
      logic               ienv_pos;
      logic [9:0]         bot;
      logic signed [10:0] ll;
      logic signed [10:0] rl;
   } g3_type;

   typedef struct packed {
      logic [12:0]        ll_y;
      logic [12:0]        rl_y;
      logic [23:0]        och_sq;
      logic [21:0]        ich_sq;
      logic               ich_pos;
      logic [25:0]        oenv_sq;
      logic [21:0]        ienv_sq;
      logic               ienv_pos;
   } g4_type;

   cfg_type cfg_ff, cfg_in;
   g1_type  g1_ff, g1_in;
   g2_type  g2_ff, g2_in;
   g3_type  g3_ff, g3_in;
   g4_type  g4_ff, g4_in;

   logic [9:0]  span;
   logic [10:0] span2;
   logic [10:0] wm1x2;
   logic [11:0] rbhw;
   logic [11:0] rbhw_p3;
   logic [10:0] raise;

   function automatic logic [10:0] clamp_level(input logic signed [10:0] lvl,
                                               input logic [9:0] bot,
                                               input logic [10:0] top);
      logic [10:0] lvl_u;
      lvl_u = lvl;
      if (lvl[10]) begin
         clamp_level = top;
      end else if (lvl_u < {1'b0, bot}) begin
         clamp_level = {1'b0, bot};
      end else if (lvl_u > top) begin
         clamp_level = top;
      end else begin
         clamp_level = lvl_u;
      end
   endfunction

   // Register file; reset values folded into the next value
   always_comb begin
      cfg_in = cfg_ff;
      if (reset) begin
         cfg_in.left_x      = 10'd0;
         cfg_in.right_x     = 10'd0;
         cfg_in.bottom      = 10'd0;
         cfg_in.top         = 10'd0;
         cfg_in.width       = 10'd1;
         cfg_in.wall        = 8'd0;
         cfg_in.left_fill   = -11'sd1;
         cfg_in.right_fill  = -11'sd1;
      end else if (csr_write_en) begin
         case (utcc_pkg::csr_index_type'(csr_index))
            utcc_pkg::CSR_LEFT_LEG_X:       cfg_in.left_x      = csr_wdata[9:0];
            utcc_pkg::CSR_RIGHT_LEG_X:      cfg_in.right_x     = csr_wdata[9:0];
            utcc_pkg::CSR_BOTTOM_ROW:       cfg_in.bottom      = csr_wdata[9:0];
            utcc_pkg::CSR_TOP_ROW:          cfg_in.top         = csr_wdata[9:0];
            utcc_pkg::CSR_TUBE_WIDTH:       cfg_in.width       = csr_wdata[9:0];
            utcc_pkg::CSR_WALL_THICKNESS:   cfg_in.wall        = csr_wdata[7:0];
            utcc_pkg::CSR_LEFT_FILL_LEVEL:  cfg_in.left_fill   = $signed(csr_wdata);
            utcc_pkg::CSR_RIGHT_FILL_LEVEL: cfg_in.right_fill  = $signed(csr_wdata);
            default:                        cfg_in             = cfg_ff;
         endcase
      end
   end

   // Stage 1: order rows, swap legs with their levels, floor width at one
   always_comb begin
      if (cfg_in.left_x > cfg_in.right_x) begin
         g1_in.lx = cfg_in.right_x;
         g1_in.rx = cfg_in.left_x;
         g1_in.ll = cfg_in.right_fill;
         g1_in.rl = cfg_in.left_fill;
      end else begin
         g1_in.lx = cfg_in.left_x;
         g1_in.rx = cfg_in.right_x;
         g1_in.ll = cfg_in.left_fill;
         g1_in.rl = cfg_in.right_fill;
      end
      if (cfg_in.bottom > cfg_in.top) begin
         g1_in.bot = cfg_in.top;
         g1_in.top = cfg_in.bottom;
      end else begin
         g1_in.bot = cfg_in.bottom;
         g1_in.top = cfg_in.top;
      end
      g1_in.w    = (cfg_in.width == 10'd0) ? 10'd1 : cfg_in.width;
      g1_in.wall = cfg_in.wall;
   end

   // Stage 2: leg centers, bend radius and center
   always_comb begin
      span        = g1_ff.rx - g1_ff.lx;
      span2       = {span, 1'b0};
      wm1x2       = {g1_ff.w - 10'd1, 1'b0};
      g2_in.hw    = {g1_ff.w, 1'b0};
      g2_in.envh  = {1'b0, g1_ff.w, 1'b0} + {2'b00, g1_ff.wall, 2'b00};
      g2_in.lc    = {1'b0, g1_ff.lx, 2'b00} + {2'b00, wm1x2};
      g2_in.rc    = {1'b0, g1_ff.rx, 2'b00} + {2'b00, wm1x2};
      g2_in.cx    = {2'b00, g1_ff.lx, 1'b0} + {2'b00, g1_ff.rx, 1'b0} + {2'b00, wm1x2};
      g2_in.rb    = (span2 < 11'd4) ? 11'd4 : span2;
      g2_in.cy    = {1'b0, g1_ff.bot, 2'b00} + {2'b00, g2_in.rb} + {2'b00, g2_in.hw};
      g2_in.bot   = g1_ff.bot;
      g2_in.top   = g1_ff.top;
      g2_in.ll    = g1_ff.ll;
      g2_in.rl    = g1_ff.rl;
   end

   // Stage 3: raise the leg top to the bend center, ring radii
   always_comb begin
      rbhw           = {1'b0, g2_ff.rb} + {1'b0, g2_ff.hw};
      rbhw_p3        = rbhw + 12'd3;
      raise          = {1'b0, g2_ff.bot} + {1'b0, rbhw_p3[11:2]};
      g3_in.top      = ({1'b0, g2_ff.top} > raise) ? {1'b0, g2_ff.top} : raise;
      g3_in.och      = rbhw;
      g3_in.ich_pos  = g2_ff.rb > g2_ff.hw;
      g3_in.ich      = g2_ff.rb - g2_ff.hw;
      g3_in.oenv     = {2'b00, g2_ff.rb} + {1'b0, g2_ff.envh};
      g3_in.ienv_pos = {1'b0, g2_ff.rb} > g2_ff.envh;
      g3_in.ienv     = 11'({1'b0, g2_ff.rb} - g2_ff.envh);
      g3_in.bot      = g2_ff.bot;
      g3_in.ll       = g2_ff.ll;
      g3_in.rl       = g2_ff.rl;
   end

   // Stage 4: clamp fill levels, square ring radii
   always_comb begin
      g4_in.ll_y     = {clamp_level(g3_ff.ll, g3_ff.bot, g3_ff.top), 2'b10};
      g4_in.rl_y     = {clamp_level(g3_ff.rl, g3_ff.bot, g3_ff.top), 2'b10};
      g4_in.och_sq   = {12'd0, g3_ff.och} * {12'd0, g3_ff.och};
      g4_in.ich_sq   = {11'd0, g3_ff.ich} * {11'd0, g3_ff.ich};
      g4_in.ich_pos  = g3_ff.ich_pos;
      g4_in.oenv_sq  = {13'd0, g3_ff.oenv} * {13'd0, g3_ff.oenv};
      g4_in.ienv_sq  = {11'd0, g3_ff.ienv} * {11'd0, g3_ff.ienv};
      g4_in.ienv_pos = g3_ff.ienv_pos;
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
      g1_ff  <= g1_in;
      g2_ff  <= g2_in;
      g3_ff  <= g3_in;
      g4_ff  <= g4_in;
   end

   always_comb begin
      geom.cx       = g2_ff.cx;
      geom.cy       = g2_ff.cy;
      geom.lc       = g2_ff.lc;
      geom.rc       = g2_ff.rc;
      geom.hw       = g2_ff.hw;
      geom.envh     = g2_ff.envh;
      geom.top_y    = {g3_ff.top, 2'b10};
      geom.ll_y     = g4_ff.ll_y;
      geom.rl_y     = g4_ff.rl_y;
      geom.och_sq   = g4_ff.och_sq;
      geom.ich_sq   = g4_ff.ich_sq;
      geom.ich_pos  = g4_ff.ich_pos;
      geom.oenv_sq  = g4_ff.oenv_sq;
      geom.ienv_sq  = g4_ff.ienv_sq;
      geom.ienv_pos = g4_ff.ienv_pos;
   end

endmodule

>>> rtl/core/utcc_datapath.sv
`include "u_tube_cell_classifier_macros.svh"

module utcc_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [9:0]         in_col,
   input  logic [9:0]         in_row,
   input  utcc_pkg::geom_type geom,
   output logic               out_valid,
   output logic               out_solid,
   output logic               out_fluid,
   output logic               out_air
);

   typedef struct packed {
      logic ge_cy;
      logic le_cy;
      logic l_ch;
      logic r_ch;
      logic l_env;
      logic r_env;
   } pos_type;

   // Stage A: input register
   logic        a_valid_ff;
   logic [9:0]  a_col_ff, a_row_ff;
   // Stage B: sample point
   logic        b_valid_ff, b_grid_ff, b_grid_in;
   logic [11:0] b_x_ff, b_y_ff;
   // Stage C: distances to centers
   logic        c_valid_ff, c_grid_ff;
   logic [11:0] c_y_ff;
   logic [12:0] c_adx_ff, c_ady_ff;
   pos_type     c_pos_ff, c_pos_in;
   // Stage D: squares
   logic        d_valid_ff, d_grid_ff, d_le_top_ff, d_le_top_in;
   logic [11:0] d_y_ff;
   logic [25:0] d_sqx_ff, d_sqy_ff;
   pos_type     d_pos_ff;
   // Stage E: result
   logic        rsp_valid_ff;
   logic        solid_ff, fluid_ff, air_ff;
   logic        solid_in, fluid_in, air_in;

   logic signed [13:0] dx, dy, dl, dr;
   logic [12:0]        adl, adr;
   logic [26:0]        d2;
   logic               bend_ch, bend_env, le_ll, le_rl, env, in_leg_top;

   function automatic logic [12:0] mag(input logic signed [13:0] v);
      mag = v[13] ? 13'(-v) : 13'(v);
   endfunction

   always_comb begin
      b_grid_in = (int'(a_col_ff) < utcc_pkg::GRID_W) && (int'(a_row_ff) < utcc_pkg::GRID_H);
   end

   always_comb begin
      dx             = $signed({2'b00, b_x_ff}) - $signed({1'b0, geom.cx});
      dy             = $signed({2'b00, b_y_ff}) - $signed({1'b0, geom.cy});
      dl             = $signed({2'b00, b_x_ff}) - $signed({1'b0, geom.lc});
      dr             = $signed({2'b00, b_x_ff}) - $signed({1'b0, geom.rc});
      adl            = mag(dl);
      adr            = mag(dr);
      c_pos_in.ge_cy = {1'b0, b_y_ff} >= geom.cy;
      c_pos_in.le_cy = {1'b0, b_y_ff} <= geom.cy;
      c_pos_in.l_ch  = adl <= {2'b00, geom.hw};
      c_pos_in.r_ch  = adr <= {2'b00, geom.hw};
      c_pos_in.l_env = adl <= {1'b0, geom.envh};
      c_pos_in.r_env = adr <= {1'b0, geom.envh};
   end

   always_comb begin
      d_le_top_in = {1'b0, c_y_ff} <= geom.top_y;
   end

   always_comb begin
      d2         = {1'b0, d_sqx_ff} + {1'b0, d_sqy_ff};
      bend_ch    = (d2 <= {3'b000, geom.och_sq}) &&
                   !(geom.ich_pos && (d2 < {5'b00000, geom.ich_sq}));
      bend_env   = (d2 <= {1'b0, geom.oenv_sq}) &&
                   !(geom.ienv_pos && (d2 < {5'b00000, geom.ienv_sq}));
      le_ll      = {1'b0, d_y_ff} <= geom.ll_y;
      le_rl      = {1'b0, d_y_ff} <= geom.rl_y;
      in_leg_top = d_pos_ff.ge_cy && d_le_top_ff;
      env        = (in_leg_top && (d_pos_ff.l_env || d_pos_ff.r_env)) ||
                   (d_pos_ff.le_cy && bend_env);
      air_in     = d_grid_ff && ((in_leg_top && (d_pos_ff.l_ch || d_pos_ff.r_ch)) ||
                                 (d_pos_ff.le_cy && bend_ch));
      fluid_in   = d_grid_ff && ((d_pos_ff.ge_cy && ((le_ll && d_pos_ff.l_ch) ||
                                                     (le_rl && d_pos_ff.r_ch))) ||
                                 (d_pos_ff.le_cy && bend_ch));
      solid_in   = d_grid_ff && env && !air_in;
   end

   // Valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= in_valid;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         rsp_valid_ff <= d_valid_ff;
      end
   end

   // Payload advances every cycle
   always_ff @(posedge clock) begin
      a_col_ff    <= in_col;
      a_row_ff    <= in_row;
      b_x_ff      <= {a_col_ff, 2'b10};
      b_y_ff      <= {a_row_ff, 2'b10};
      b_grid_ff   <= b_grid_in;
      c_adx_ff    <= mag(dx);
      c_ady_ff    <= mag(dy);
      c_y_ff      <= b_y_ff;
      c_pos_ff    <= c_pos_in;
      c_grid_ff   <= b_grid_ff;
      d_sqx_ff    <= {13'd0, c_adx_ff} * {13'd0, c_adx_ff};
      d_sqy_ff    <= {13'd0, c_ady_ff} * {13'd0, c_ady_ff};
      d_y_ff      <= c_y_ff;
      d_pos_ff    <= c_pos_ff;
      d_le_top_ff <= d_le_top_in;
      d_grid_ff   <= c_grid_ff;
      solid_ff    <= solid_in;
      fluid_ff    <= fluid_in;
      air_ff      <= air_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_solid = solid_ff;
   assign out_fluid = fluid_ff;
   assign out_air   = air_ff;

   `UTCC_ASSERT_IMPL(a_fluid_in_air, rsp_valid_ff && fluid_ff, air_ff, "fluid cell outside channel")
   `UTCC_ASSERT_NEVER(a_solid_not_air, rsp_valid_ff && solid_ff && air_ff, "wall cell in channel")
   `UTCC_ASSERT_IMPL(a_item_delivered, a_valid_ff, ##4 rsp_valid_ff, "item lost in pipeline")
   `UTCC_ASSERT_IMPL(a_no_extra_result, rsp_valid_ff, $past(a_valid_ff, 4), "result without item")

endmodule

>>> rtl/core/u_tube_cell_classifier.sv
// U-tube cell classifier.
// Item channel: drive req_cell_col/req_cell_row with start; the item is taken
// at a rising edge where start is high and busy is low. busy is high only in
// reset and the cycle after it, so a new cell can be taken every cycle.
// Result channel: rsp_valid pulses for one cycle with rsp_make_solid,
// rsp_make_fluid and rsp_make_air. A result shows once its item has passed
// five register stages (input, sample point, center distances, squares,
// result), in the same order as the items. The receiver cannot stall the
// block, so every result must be taken as it appears.
// Throughput: one cell per cycle while busy is low.
// Configuration: csr_write_en/csr_index/csr_wdata write one register per
// cycle; write only while no item is in flight. The normalized geometry is
// rebuilt in a four-stage pipeline that starts from the incoming write, so
// an item taken at the same edge as a write, or after it, sees the new tube.
// Reset (synchronous) restores tube width one, both fill levels at the top
// row, all other registers zero, and drops any item in flight.
module u_tube_cell_classifier (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [9:0]                       req_cell_col,
   input  logic [9:0]                       req_cell_row,
   output logic                             rsp_valid,
   output logic                             rsp_make_solid,
   output logic                             rsp_make_fluid,
   output logic                             rsp_make_air,
   input  logic                             csr_write_en,
   input  logic [utcc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [utcc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   utcc_pkg::geom_type geom;
   logic               busy_ff;
   logic               item_accept;

   // Hold busy through reset and the cycle after it
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy        = busy_ff || reset;
   assign item_accept = start && !busy;

   // Configuration registers and the normalized tube
   utcc_geom u_geom (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .geom         (geom)
   );

   // Per-cell classification pipeline
   utcc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (item_accept),
      .in_col    (req_cell_col),
      .in_row    (req_cell_row),
      .geom      (geom),
      .out_valid (rsp_valid),
      .out_solid (rsp_make_solid),
      .out_fluid (rsp_make_fluid),
      .out_air   (rsp_make_air)
   );

endmodule

>>> verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Run limits. The cycle limit is far above the slowest legal run
   // (about 700 cells, each behind at most the longest idle gap, plus drains).
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int RANDOM_PHASES   = 13;
   localparam int CELLS_PER_PHASE = 50;

   typedef struct packed {
      logic solid;
      logic fluid;
      logic air;
   } cell_flags_type;

   typedef struct {
      bit [9:0]       col;
      bit [9:0]       row;
      cell_flags_type flags;
   } cell_expect_type;

   typedef enum {TUBE_COMPACT, TUBE_SPREAD, TUBE_EXTREME} tube_kind_type;

   // Scoreboard: holds its own copy of the tube registers, works out the
   // flags of every accepted cell and matches them against the results.
   class tube_scoreboard;
      bit [9:0]         left_x, right_x, bottom, top, width;
      bit [7:0]         wall;
      bit signed [10:0] left_lvl, right_lvl;
      // Normalized shape: centers, radius and half width in quarter cells, rows and levels in cells.
      longint           g_lc, g_rc, g_cx, g_cy, g_rb, g_hw, g_bot, g_top, g_llev, g_rlev;
      cell_expect_type  flag_q[$];
      int               mismatches;

      function new();
         left_x    = 0;
         right_x   = 0;
         bottom    = 0;
         top       = 0;
         width     = 1;
         wall      = 0;
         left_lvl  = -1;
         right_lvl = -1;
         mismatches = 0;
      endfunction

      function void write_reg(utcc_pkg::csr_index_type idx, logic [10:0] data);
         case (idx)
            utcc_pkg::CSR_LEFT_LEG_X:       left_x    = data[9:0];
            utcc_pkg::CSR_RIGHT_LEG_X:      right_x   = data[9:0];
            utcc_pkg::CSR_BOTTOM_ROW:       bottom    = data[9:0];
            utcc_pkg::CSR_TOP_ROW:          top       = data[9:0];
            utcc_pkg::CSR_TUBE_WIDTH:       width     = data[9:0];
            utcc_pkg::CSR_WALL_THICKNESS:   wall      = data[7:0];
            utcc_pkg::CSR_LEFT_FILL_LEVEL:  left_lvl  = data;
            utcc_pkg::CSR_RIGHT_FILL_LEVEL: right_lvl = data;
            default: ;
         endcase
      endfunction

      function void build_shape();
         longint lx, rx, b, t, w, ll, rl, swp, raised;
         lx = left_x;
         rx = right_x;
         b  = bottom;
         t  = top;
         w  = width;
         if (w < 1) w = 1;
         ll = left_lvl;
         rl = right_lvl;
         if (b > t) begin
            swp = b; b = t; t = swp;
         end
         // Legs swap together with their fill levels.
         if (lx > rx) begin
            swp = lx; lx = rx; rx = swp;
            swp = ll; ll = rl; rl = swp;
         end
         g_hw = 2 * w;
         g_lc = 4 * lx + 2 * (w - 1);
         g_rc = 4 * rx + 2 * (w - 1);
         g_cx = (g_lc + g_rc) / 2;
         g_rb = 2 * (rx - lx);
         if (g_rb < 4) g_rb = 4;
         g_cy = 4 * b + g_rb + g_hw;
         raised = (g_cy + 3) / 4;
         if (t < raised) t = raised;
         if (ll < 0) ll = t;
         if (rl < 0) rl = t;
         if (ll < b) ll = b;
         if (ll > t) ll = t;
         if (rl < b) rl = b;
         if (rl > t) rl = t;
         g_bot  = b;
         g_top  = t;
         g_llev = ll;
         g_rlev = rl;
      endfunction

      function bit in_leg(longint x, longint y, longint h, longint ltop, longint rtop);
         longint dl, dr;
         dl = x - g_lc;
         dr = x - g_rc;
         if (dl < 0) dl = -dl;
         if (dr < 0) dr = -dr;
         if (y < g_cy) return 1'b0;
         if (y <= 4 * ltop + 2 && dl <= h) return 1'b1;
         if (y <= 4 * rtop + 2 && dr <= h) return 1'b1;
         return 1'b0;
      endfunction

      function bit in_bend(longint x, longint y, longint h);
         longint dx, dy, d2, outer, inner;
         if (y > g_cy) return 1'b0;
         dx    = x - g_cx;
         dy    = y - g_cy;
         d2    = dx * dx + dy * dy;
         outer = g_rb + h;
         inner = g_rb - h;
         if (d2 > outer * outer) return 1'b0;
         if (inner > 0 && d2 < inner * inner) return 1'b0;
         return 1'b1;
      endfunction

      function cell_flags_type classify(bit [9:0] col, bit [9:0] row);
         longint         x, y, env_h;
         bit             env, air, fluid;
         cell_flags_type f;
         build_shape();
         x = col;
         y = row;
         x = 4 * x + 2;
         y = 4 * y + 2;
         env_h = wall;
         env_h = g_hw + 4 * env_h;
         env   = in_leg(x, y, env_h, g_top, g_top) || in_bend(x, y, env_h);
         air   = in_leg(x, y, g_hw, g_top, g_top) || in_bend(x, y, g_hw);
         fluid = in_leg(x, y, g_hw, g_llev, g_rlev) || in_bend(x, y, g_hw);
         f.solid = env && !air;
         f.fluid = fluid;
         f.air   = air;
         return f;
      endfunction

      function void note_cell(bit [9:0] col, bit [9:0] row);
         cell_expect_type e;
         e.col   = col;
         e.row   = row;
         e.flags = classify(col, row);
         flag_q.insert(flag_q.size(), e);
      endfunction

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         mismatches++;
      endtask

      task check_flags(cell_flags_type got);
         cell_expect_type want;
         if (flag_q.size() == 0) begin
            report_mismatch($sformatf("result with no cell pending, solid %0b fluid %0b air %0b",
                                      got.solid, got.fluid, got.air));
            return;
         end
         want = flag_q.pop_front();
         if (got.solid !== want.flags.solid)
            report_mismatch($sformatf("cell (%0d,%0d) solid %0b, want %0b",
                                      want.col, want.row, got.solid, want.flags.solid));
         if (got.fluid !== want.flags.fluid)
            report_mismatch($sformatf("cell (%0d,%0d) fluid %0b, want %0b",
                                      want.col, want.row, got.fluid, want.flags.fluid));
         if (got.air !== want.flags.air)
            report_mismatch($sformatf("cell (%0d,%0d) air %0b, want %0b",
                                      want.col, want.row, got.air, want.flags.air));
      endtask
   endclass

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [9:0]                      req_cell_col;
   logic [9:0]                      req_cell_row;
   logic                            rsp_valid;
   logic                            rsp_make_solid;
   logic                            rsp_make_fluid;
   logic                            rsp_make_air;
   logic                            csr_write_en;
   logic [utcc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [utcc_pkg::CSR_DATA_W-1:0] csr_wdata;

   tube_scoreboard sb;
   int             cycle_count;

   u_tube_cell_classifier dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cell_col   (req_cell_col),
      .req_cell_row   (req_cell_row),
      .rsp_valid      (rsp_valid),
      .rsp_make_solid (rsp_make_solid),
      .rsp_make_fluid (rsp_make_fluid),
      .rsp_make_air   (rsp_make_air),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Watchdog: a hung handshake or a lost result ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result side: the block cannot be stalled, so sample every strobe.
   // Values read here are the ones present before this edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_flags(cell_flags_type'({rsp_make_solid, rsp_make_fluid, rsp_make_air}));
   end

   // Idle gap before a cell: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one cell and hold it until the block takes it. Start stays
   // high on return so back-to-back cells keep start high throughout.
   task automatic send_cell(bit [9:0] col, bit [9:0] row, bit quiet);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_cell_col <= col;
      req_cell_row <= row;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_cell(col, row);
   endtask

   // Drop start, wait for every pending cell, then let the pipe settle.
   task automatic drain_cells();
      start <= 1'b0;
      while (sb.flag_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(utcc_pkg::csr_index_type idx, logic [10:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Program the whole tube; only called while no cell is in flight.
   task automatic program_tube(logic [10:0] lx, logic [10:0] rx, logic [10:0] bot,
                               logic [10:0] tp, logic [10:0] w, logic [10:0] wl,
                               logic [10:0] llev, logic [10:0] rlev);
      write_reg(utcc_pkg::CSR_LEFT_LEG_X, lx);
      write_reg(utcc_pkg::CSR_RIGHT_LEG_X, rx);
      write_reg(utcc_pkg::CSR_BOTTOM_ROW, bot);
      write_reg(utcc_pkg::CSR_TOP_ROW, tp);
      write_reg(utcc_pkg::CSR_TUBE_WIDTH, w);
      write_reg(utcc_pkg::CSR_WALL_THICKNESS, wl);
      write_reg(utcc_pkg::CSR_LEFT_FILL_LEVEL, llev);
      write_reg(utcc_pkg::CSR_RIGHT_FILL_LEVEL, rlev);
      csr_write_en <= 1'b0;
   endtask

   // Ten-bit register value with a random unused top bit.
   function automatic logic [10:0] with_junk10(int v);
      return {1'($urandom_range(0, 1)), 10'(v)};
   endfunction

   function automatic logic [10:0] pick_level(int lim);
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return 11'h7FF;
      if (r == 2) return 11'(-int'($urandom_range(1, 1024)));
      return 11'($urandom_range(0, lim));
   endfunction

   function automatic int pick_edge10();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 1023;
         default: return $urandom_range(0, 1023);
      endcase
   endfunction

   function automatic logic [10:0] pick_edge_level();
      case ($urandom_range(0, 3))
         0: return 11'h400;
         1: return 11'h7FF;
         2: return 11'd0;
         default: return 11'd1023;
      endcase
   endfunction

   task automatic program_random_tube(tube_kind_type kind);
      logic [10:0] wl;
      case (kind)
         TUBE_COMPACT: begin
            wl = {3'($urandom_range(0, 7)), 8'($urandom_range(0, 5))};
            program_tube(with_junk10($urandom_range(0, 60)), with_junk10($urandom_range(0, 60)),
                         with_junk10($urandom_range(0, 60)), with_junk10($urandom_range(0, 90)),
                         with_junk10($urandom_range(0, 6)), wl,
                         pick_level(90), pick_level(90));
         end
         TUBE_SPREAD: begin
            wl = {3'($urandom_range(0, 7)), 8'($urandom_range(0, 20))};
            program_tube(with_junk10($urandom_range(0, 1023)),
                         with_junk10($urandom_range(0, 1023)),
                         with_junk10($urandom_range(0, 1023)),
                         with_junk10($urandom_range(0, 1023)),
                         with_junk10($urandom_range(0, 40)), wl,
                         pick_level(1023), pick_level(1023));
         end
         default: begin
            case ($urandom_range(0, 2))
               0: wl = 11'd0;
               1: wl = 11'd255;
               default: wl = 11'($urandom_range(0, 2047));
            endcase
            program_tube(with_junk10(pick_edge10()), with_junk10(pick_edge10()),
                         with_junk10(pick_edge10()), with_junk10(pick_edge10()),
                         with_junk10(pick_edge10()), wl,
                         pick_edge_level(), pick_edge_level());
         end
      endcase
   endtask

   // Aim most cells at the box around the tube envelope so the wall,
   // channel and level edges get hit; keep some uniform noise.
   task automatic pick_cell(output bit [9:0] col, output bit [9:0] row);
      longint c_lo, c_hi, r_lo, r_hi, reach;
      if ($urandom_range(0, 99) < 15) begin
         col = 10'($urandom_range(0, 1023));
         row = 10'($urandom_range(0, 1023));
      end else begin
         sb.build_shape();
         reach = sb.wall;
         reach = sb.g_hw + 4 * reach;
         c_lo = (sb.g_lc - reach) / 4 - 2;
         c_hi = (sb.g_rc + reach) / 4 + 2;
         r_lo = sb.g_bot - sb.wall - 2;
         r_hi = sb.g_top + 2;
         if (c_lo < 0) c_lo = 0;
         if (r_lo < 0) r_lo = 0;
         if (c_lo > 1023) c_lo = 1023;
         if (r_lo > 1023) r_lo = 1023;
         if (c_hi > 1023) c_hi = 1023;
         if (r_hi > 1023) r_hi = 1023;
         col = 10'($urandom_range(int'(c_hi), int'(c_lo)));
         row = 10'($urandom_range(int'(r_hi), int'(r_lo)));
      end
   endtask

   initial begin
      bit [9:0]      col, row;
      bit            quiet;
      tube_kind_type kind;
      sb = new();
      cycle_count  <= 0;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_cell_col <= '0;
      req_cell_row <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= utcc_pkg::CSR_LEFT_LEG_X;
      csr_wdata    <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset tube: grid corners and the small bend at the origin, with
      // both fill levels standing for the top row.
      send_cell(10'd0, 10'd0, 1'b0);
      send_cell(10'd1023, 10'd1023, 1'b0);
      send_cell(10'd0, 10'd1023, 1'b0);
      send_cell(10'd1023, 10'd0, 1'b0);
      send_cell(10'd0, 10'd1, 1'b1);
      send_cell(10'd1, 10'd0, 1'b1);
      send_cell(10'd1, 10'd1, 1'b1);
      send_cell(10'd2, 10'd2, 1'b0);
      drain_cells();

      // Legs given in the wrong order and rows given upside down: the legs
      // swap with their levels, the left level means top row and the right
      // one sits inside the legs.
      program_tube(11'd20, 11'd8, 11'd40, 11'd5, 11'd3, 11'd2, 11'd35, 11'h7FF);
      send_cell(10'd9, 10'd40, 1'b0);
      send_cell(10'd21, 10'd35, 1'b1);
      send_cell(10'd21, 10'd36, 1'b1);
      send_cell(10'd9, 10'd36, 1'b0);
      send_cell(10'd9, 10'd5, 1'b0);
      send_cell(10'd15, 10'd5, 1'b1);
      send_cell(10'd7, 10'd20, 1'b0);
      drain_cells();

      // Top row below the bend center gets raised; left level under the
      // bottom and right level over the top both clamp.
      program_tube(11'd0, 11'd40, 11'd10, 11'd10, 11'd2, 11'd1, 11'd3, 11'd1000);
      send_cell(10'd0, 10'd10, 1'b0);
      send_cell(10'd0, 10'd11, 1'b1);
      send_cell(10'd40, 10'd30, 1'b0);
      send_cell(10'd40, 10'd31, 1'b1);
      send_cell(10'd20, 10'd10, 1'b0);
      send_cell(10'd20, 10'd0, 1'b0);
      send_cell(10'd0, 10'd32, 1'b1);
      drain_cells();

      // Random part: mostly compact tubes, some spread out, some at the
      // register extremes. About one phase in four runs without gaps.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 5)
            1: kind = TUBE_SPREAD;
            3: kind = TUBE_EXTREME;
            default: kind = TUBE_COMPACT;
         endcase
         program_random_tube(kind);
         quiet = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < CELLS_PER_PHASE; i++) begin
            pick_cell(col, row);
            send_cell(col, row, quiet);
         end
         drain_cells();
      end

      if (sb.flag_q.size() != 0)
         sb.report_mismatch($sformatf("%0d cells never answered", sb.flag_q.size()));
      if (sb.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
